[sv/qptl_pkg.sv]
// shared types, constants and arithmetic helpers for the quadrotor position torque law
// no dependencies; used by quadrotor_position_torque_law
package qptl_pkg;

  // one input beat
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [63:0]        attitude_quaternion;
    logic signed [31:0] gyro_roll_rate;
    logic signed [31:0] gyro_pitch_rate;
    logic signed [31:0] gyro_yaw_rate;
    logic signed [15:0] mode_switch_angle;
    logic [15:0]        manual_thrust_raw;
  } in_item_t;

  // one result beat
  typedef struct packed {
    logic signed [31:0] roll_torque;
    logic signed [31:0] pitch_torque;
    logic signed [31:0] yaw_torque;
    logic [30:0]        thrust_command;
  } out_item_t;

  // configuration register map
  typedef enum logic [2:0] {
    REG_TARGET_X,
    REG_TARGET_Y,
    REG_TARGET_Z,
    REG_GAIN_POSITION,
    REG_GAIN_DERIVATIVE,
    REG_GAIN_RATE_DAMPING,
    REG_FORCE_LIMIT,
    REG_SMOOTHING_OFFSET
  } reg_index_t;

  // register reset values
  localparam logic [31:0] TARGET_X_RST          = 32'd65536;
  localparam logic [31:0] TARGET_Y_RST          = 32'd131072;
  localparam logic [31:0] TARGET_Z_RST          = 32'd45875;
  localparam logic [31:0] GAIN_POSITION_RST     = 32'd16777216;
  localparam logic [31:0] GAIN_DERIVATIVE_RST   = 32'd30198989;
  localparam logic [31:0] GAIN_RATE_DAMPING_RST = 32'd16777;
  localparam logic [31:0] FORCE_LIMIT_RST       = 32'd167772;
  localparam logic [31:0] SMOOTHING_OFFSET_RST  = 32'd1677722;

  // physical constants in fixed point
  localparam logic signed [20:0] MASS_Q24         = 21'sd578814;
  localparam logic signed [20:0] GRAVITY_Q16      = 21'sd642908;
  localparam logic signed [19:0] DEG2RAD_Q24      = 20'sd292818;
  localparam logic [15:0]        MANUAL_SCALE_Q24 = 16'd38726;
  localparam logic signed [15:0] MODE_LIMIT_Q8    = 16'sd5120;
  localparam logic [40:0]        GAIN_ONE_Q24     = 41'd16777216;
  localparam logic [30:0]        THRUST_MAX       = 31'h7FFFFFFF;

  // pipeline shape
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned PIPE_DEPTH = 9 + SQRT_STEPS + DIV_STEPS + 6;

  // square root iteration state
  typedef struct packed {
    logic [63:0] n;
    logic [63:0] res;
  } sq_t;

  // divider iteration state
  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] quo;
  } dv_t;

  // right shift rounding to nearest, ties up
  function automatic logic signed [63:0] rshr64(input logic signed [63:0] x,
                                                input int unsigned s);
    logic signed [63:0] half;
    half = 64'sd1 <<< (s - 1);
    return (x + half) >>> s;
  endfunction

  // saturate to the signed 32 bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] y;
    if (x > 64'sd2147483647) begin
      y = 32'sh7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      y = 32'sh80000000;
    end else begin
      y = x[31:0];
    end
    return y;
  endfunction

  // one digit of the integer square root
  function automatic sq_t sqrt_step(input sq_t x, input int unsigned k);
    sq_t y;
    logic [63:0] bit_v;
    logic [63:0] trial;
    bit_v = 64'd1 << (62 - 2 * k);
    trial = x.res + bit_v;
    if (x.n >= trial) begin
      y.n   = x.n - trial;
      y.res = (x.res >> 1) + bit_v;
    end else begin
      y.n   = x.n;
      y.res = x.res >> 1;
    end
    return y;
  endfunction

  // one quotient bit of the restoring divider, msb first
  function automatic dv_t div_step(input dv_t x, input logic [31:0] root,
                                   input int unsigned k);
    dv_t y;
    logic [63:0] sub;
    sub = 64'(root) << (31 - k);
    y   = x;
    if (x.rem >= sub) begin
      y.rem = x.rem - sub;
      y.quo = x.quo | (32'd1 << (31 - k));
    end
    return y;
  endfunction

endpackage

[sv/quadrotor_position_torque_law.sv]
// quadrotor pd position law giving attitude torques and collective thrust
// depends on qptl_pkg for types, constants and arithmetic helpers

// Fully pipelined: a new start beat is taken on every clock cycle and busy stays
// low. Each result shows on result with done high for exactly one cycle, and the
// receiver cannot stall it. The pipeline runs two 32-step integer square roots
// (force norm and smoothed norm) side by side, followed by a 32-step restoring
// divider that scales the limited force.
// Configuration writes are taken on any cycle but must only be issued while no
// start beat is in flight.
module quadrotor_position_torque_law (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  qptl_pkg::in_item_t     item,
  output logic                   done,
  output qptl_pkg::out_item_t    result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  qptl_pkg::reg_index_t   cfg_index,
  input  logic [31:0]            cfg_data
);

  // per-beat side data carried along the pipeline
  typedef struct packed {
    logic [63:0]       quat;
    logic [2:0][47:0]  damp;
    logic [30:0]       man_thr;
    logic              man_sel;
    logic [2:0][31:0]  f;
    logic [2:0][63:0]  mag;
    logic [2:0]        neg;
    logic              lim;
    logic [31:0]       root;
    logic [31:0]       tn;
  } side_t;

  // configuration registers
  logic [31:0] target_x, target_y, target_z;
  logic [31:0] gain_position, gain_derivative, gain_rate_damping;
  logic [31:0] force_limit, smoothing_offset;

  // derived gains
  logic [63:0] kp_kd;
  logic [40:0] av_sum;
  logic [32:0] bv_sum;
  logic [31:0] gain_a, gain_b;
  logic [63:0] alpha_sq;
  logic signed [32:0] a_s, b_s, kw_s, alpha_s;

  // valid bits
  logic [qptl_pkg::PIPE_DEPTH-1:0] vld;

  // front stages
  qptl_pkg::in_item_t s0;
  logic signed [31:0] tgt_v [3];
  logic signed [31:0] pos_v [3];
  logic signed [31:0] vel_v [3];
  logic signed [32:0] gyro_v [3];
  logic [31:0]        man_prod;
  logic signed [31:0] s1_err [3];
  logic signed [31:0] s1_vel [3];
  logic signed [52:0] s1_gprod [3];
  logic signed [63:0] s2_ae [3];
  logic signed [63:0] s2_bv [3];
  logic signed [29:0] s2_grad [3];
  logic signed [41:0] s3_s [3];
  logic signed [63:0] s3_dprod [3];
  logic signed [63:0] s4_m [3];
  logic signed [63:0] s6_fsq [3];
  logic signed [63:0] s6_num [3];
  logic [63:0]        s7_n2;
  logic signed [63:0] s7_num [3];
  logic [64:0]        sum65;
  side_t sd1, sd2, sd3, sd4, sd5, sd6, sd7;
  side_t sd1_next, sd4_next, sd5_next, sd_sq_next, sd_sel_next;

  // square root and divider chains
  qptl_pkg::sq_t sq_a [qptl_pkg::SQRT_STEPS+1];
  qptl_pkg::sq_t sq_b [qptl_pkg::SQRT_STEPS+1];
  side_t         sd_sq [qptl_pkg::SQRT_STEPS+1];
  qptl_pkg::dv_t dv_first [3];
  side_t         sd_dv_first;
  qptl_pkg::dv_t dv [qptl_pkg::DIV_STEPS][3];
  side_t         sd_dv [qptl_pkg::DIV_STEPS];

  // back stages
  side_t sd_sel, sd_r1, sd_r2, sd_r3, sd_r4;
  logic signed [31:0] comp [3];
  logic signed [15:0] qa [4];
  logic signed [15:0] qb [4];
  logic signed [47:0] r1_p [9];
  logic signed [31:0] r1_q00;
  logic signed [37:0] r2_qvf;
  logic signed [37:0] r2_c [3];
  logic signed [17:0] r2_q00;
  logic signed [63:0] r3_tx [5];
  logic signed [63:0] r3_ty [5];
  logic signed [47:0] r4_bx, r4_by;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign done      = vld[qptl_pkg::PIPE_DEPTH-1];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_x          <= qptl_pkg::TARGET_X_RST;
      target_y          <= qptl_pkg::TARGET_Y_RST;
      target_z          <= qptl_pkg::TARGET_Z_RST;
      gain_position     <= qptl_pkg::GAIN_POSITION_RST;
      gain_derivative   <= qptl_pkg::GAIN_DERIVATIVE_RST;
      gain_rate_damping <= qptl_pkg::GAIN_RATE_DAMPING_RST;
      force_limit       <= qptl_pkg::FORCE_LIMIT_RST;
      smoothing_offset  <= qptl_pkg::SMOOTHING_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        qptl_pkg::REG_TARGET_X:          target_x          <= cfg_data;
        qptl_pkg::REG_TARGET_Y:          target_y          <= cfg_data;
        qptl_pkg::REG_TARGET_Z:          target_z          <= cfg_data;
        qptl_pkg::REG_GAIN_POSITION:     gain_position     <= cfg_data;
        qptl_pkg::REG_GAIN_DERIVATIVE:   gain_derivative   <= cfg_data;
        qptl_pkg::REG_GAIN_RATE_DAMPING: gain_rate_damping <= cfg_data;
        qptl_pkg::REG_FORCE_LIMIT:       force_limit       <= cfg_data;
        qptl_pkg::REG_SMOOTHING_OFFSET:  smoothing_offset  <= cfg_data;
        default:                         target_x          <= target_x;
      endcase
    end
  end

  // combined pd gains and squared force limit
  always_comb begin
    kp_kd  = 64'(gain_position) * 64'(gain_derivative);
    av_sum = 41'(kp_kd[63:24]) + qptl_pkg::GAIN_ONE_Q24;
    bv_sum = 33'(gain_position) + 33'(gain_derivative);
  end

  always_ff @(posedge clk) begin
    gain_a   <= (av_sum > 41'hFFFFFFFF) ? 32'hFFFFFFFF : av_sum[31:0];
    gain_b   <= bv_sum[32] ? 32'hFFFFFFFF : bv_sum[31:0];
    alpha_sq <= 64'(force_limit) * 64'(force_limit);
  end

  assign a_s     = $signed({1'b0, gain_a});
  assign b_s     = $signed({1'b0, gain_b});
  assign kw_s    = $signed({1'b0, gain_rate_damping});
  assign alpha_s = $signed({1'b0, force_limit});

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[qptl_pkg::PIPE_DEPTH-2:0], start && !busy};
    end
  end

  // stage 0: input capture
  always_ff @(posedge clk) begin
    s0 <= item;
  end

  // per-axis views of the captured beat
  always_comb begin
    tgt_v[0]  = $signed(target_x);
    tgt_v[1]  = $signed(target_y);
    tgt_v[2]  = $signed(target_z);
    pos_v[0]  = s0.pos_x;
    pos_v[1]  = s0.pos_y;
    pos_v[2]  = s0.pos_z;
    vel_v[0]  = s0.vel_x;
    vel_v[1]  = s0.vel_y;
    vel_v[2]  = s0.vel_z;
    gyro_v[0] = 33'(s0.gyro_roll_rate);
    gyro_v[1] = -33'(s0.gyro_pitch_rate);
    gyro_v[2] = 33'(s0.gyro_yaw_rate);
    man_prod  = 32'(s0.manual_thrust_raw) * 32'(qptl_pkg::MANUAL_SCALE_Q24);
    sd1_next         = '0;
    sd1_next.quat    = s0.attitude_quaternion;
    sd1_next.man_thr = man_prod[31] ? qptl_pkg::THRUST_MAX : man_prod[30:0];
    sd1_next.man_sel = s0.mode_switch_angle < qptl_pkg::MODE_LIMIT_Q8;
  end

  // stage 1: position error, rate conversion, manual thrust
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s1_err[k]   <= qptl_pkg::sat32(64'(33'(tgt_v[k]) - 33'(pos_v[k])));
      s1_vel[k]   <= vel_v[k];
      s1_gprod[k] <= gyro_v[k] * qptl_pkg::DEG2RAD_Q24;
    end
    sd1 <= sd1_next;
  end

  // stage 2: gain products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s2_ae[k]   <= s1_err[k] * a_s;
      s2_bv[k]   <= s1_vel[k] * b_s;
      s2_grad[k] <= 30'(qptl_pkg::rshr64(64'(s1_gprod[k]), 24));
    end
    sd2 <= sd1;
  end

  // stage 3: pd sum, rate damping product
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s3_s[k] <= 42'(qptl_pkg::rshr64(s2_ae[k], 24) - qptl_pkg::rshr64(s2_bv[k], 24)
                     + ((k == 2) ? 64'(qptl_pkg::GRAVITY_Q16) : 64'sd0));
      s3_dprod[k] <= s2_grad[k] * kw_s;
    end
    sd3 <= sd2;
  end

  // rate damping rounding
  always_comb begin
    sd4_next = sd3;
    for (int k = 0; k < 3; k++) begin
      sd4_next.damp[k] = 48'(qptl_pkg::rshr64(s3_dprod[k], 16));
    end
  end

  // stage 4: mass product, rate damping
  always_ff @(posedge clk) begin
    sd4 <= sd4_next;
    for (int k = 0; k < 3; k++) begin
      s4_m[k] <= s3_s[k] * qptl_pkg::MASS_Q24;
    end
  end

  // force rounding and saturation
  always_comb begin
    sd5_next = sd4;
    for (int k = 0; k < 3; k++) begin
      sd5_next.f[k] = qptl_pkg::sat32(qptl_pkg::rshr64(s4_m[k], 16));
    end
  end

  // stage 5: force components
  always_ff @(posedge clk) begin
    sd5 <= sd5_next;
  end

  // stage 6: squares and limit numerators
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s6_fsq[k] <= $signed(sd5.f[k]) * $signed(sd5.f[k]);
      s6_num[k] <= $signed(sd5.f[k]) * alpha_s;
    end
    sd6 <= sd5;
  end

  // stage 7: squared norm
  always_ff @(posedge clk) begin
    s7_n2  <= s6_fsq[0] + s6_fsq[1] + s6_fsq[2];
    s7_num <= s6_num;
    sd7    <= sd6;
  end

  assign sum65 = {1'b0, s7_n2} + 65'({smoothing_offset, 24'd0});

  // limit decision and numerator magnitudes
  always_comb begin
    sd_sq_next     = sd7;
    sd_sq_next.lim = s7_n2 > alpha_sq;
    for (int k = 0; k < 3; k++) begin
      sd_sq_next.neg[k] = s7_num[k][63];
      sd_sq_next.mag[k] = s7_num[k][63] ? 64'(-s7_num[k]) : 64'(s7_num[k]);
    end
  end

  // stage 8: limit decision and square root setup
  always_ff @(posedge clk) begin
    sq_a[0].n   <= s7_n2;
    sq_a[0].res <= '0;
    sq_b[0].n   <= sum65[64] ? 64'hFFFFFFFFFFFFFFFF : sum65[63:0];
    sq_b[0].res <= '0;
    sd_sq[0]    <= sd_sq_next;
  end

  // square root chains, one digit per stage
  for (genvar k = 0; k < qptl_pkg::SQRT_STEPS; k++) begin : g_sqrt
    always_ff @(posedge clk) begin
      sq_a[k+1]  <= qptl_pkg::sqrt_step(sq_a[k], k);
      sq_b[k+1]  <= qptl_pkg::sqrt_step(sq_b[k], k);
      sd_sq[k+1] <= sd_sq[k];
    end
  end

  // divider setup from the roots
  always_comb begin
    sd_dv_first      = sd_sq[qptl_pkg::SQRT_STEPS];
    sd_dv_first.root = sq_b[qptl_pkg::SQRT_STEPS].res[31:0];
    sd_dv_first.tn   = sq_a[qptl_pkg::SQRT_STEPS].res[31:0];
    for (int a = 0; a < 3; a++) begin
      dv_first[a].rem = sd_sq[qptl_pkg::SQRT_STEPS].mag[a];
      dv_first[a].quo = '0;
    end
  end

  // divider chain, one quotient bit per stage
  for (genvar k = 0; k < qptl_pkg::DIV_STEPS; k++) begin : g_div
    if (k == 0) begin : g_head
      always_ff @(posedge clk) begin
        sd_dv[0] <= sd_dv_first;
        for (int a = 0; a < 3; a++) begin
          dv[0][a] <= qptl_pkg::div_step(dv_first[a], sd_dv_first.root, 0);
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        sd_dv[k] <= sd_dv[k-1];
        for (int a = 0; a < 3; a++) begin
          dv[k][a] <= qptl_pkg::div_step(dv[k-1][a], sd_dv[k-1].root, k);
        end
      end
    end
  end

  // signed, saturated limited components and the force select
  always_comb begin
    sd_sel_next = sd_dv[qptl_pkg::DIV_STEPS-1];
    for (int a = 0; a < 3; a++) begin
      if (sd_dv[qptl_pkg::DIV_STEPS-1].neg[a]) begin
        comp[a] = -$signed(dv[qptl_pkg::DIV_STEPS-1][a].quo[31] ? 32'h80000000
                                                             : dv[qptl_pkg::DIV_STEPS-1][a].quo);
      end else begin
        comp[a] = $signed(dv[qptl_pkg::DIV_STEPS-1][a].quo[31] ? 32'h7FFFFFFF
                                                            : dv[qptl_pkg::DIV_STEPS-1][a].quo);
      end
      if (sd_dv[qptl_pkg::DIV_STEPS-1].lim) begin
        sd_sel_next.f[a] = comp[a];
      end
    end
  end

  // select limited or plain force
  always_ff @(posedge clk) begin
    sd_sel <= sd_sel_next;
  end

  // quaternion components
  always_comb begin
    qa[0] = $signed(sd_sel.quat[63:48]);
    qa[1] = $signed(sd_sel.quat[47:32]);
    qa[2] = $signed(sd_sel.quat[31:16]);
    qa[3] = $signed(sd_sel.quat[15:0]);
    qb[0] = $signed(sd_r2.quat[63:48]);
    qb[1] = $signed(sd_r2.quat[47:32]);
    qb[2] = $signed(sd_r2.quat[31:16]);
    qb[3] = $signed(sd_r2.quat[15:0]);
  end

  // rotation 1: first quaternion products
  always_ff @(posedge clk) begin
    r1_p[0] <= qa[1] * $signed(sd_sel.f[0]);
    r1_p[1] <= qa[2] * $signed(sd_sel.f[1]);
    r1_p[2] <= qa[3] * $signed(sd_sel.f[2]);
    r1_p[3] <= $signed(sd_sel.f[1]) * qa[3];
    r1_p[4] <= qa[2] * $signed(sd_sel.f[2]);
    r1_p[5] <= qa[1] * $signed(sd_sel.f[2]);
    r1_p[6] <= $signed(sd_sel.f[0]) * qa[3];
    r1_p[7] <= $signed(sd_sel.f[0]) * qa[2];
    r1_p[8] <= qa[1] * $signed(sd_sel.f[1]);
    r1_q00  <= qa[0] * qa[0];
    sd_r1   <= sd_sel;
  end

  // rotation 2: dot, cross and w squared
  always_ff @(posedge clk) begin
    r2_qvf  <= 38'(qptl_pkg::rshr64(64'(r1_p[0]) + 64'(r1_p[1]) + 64'(r1_p[2]), 14));
    r2_c[0] <= 38'(qptl_pkg::rshr64(64'(r1_p[3]) - 64'(r1_p[4]), 14));
    r2_c[1] <= 38'(qptl_pkg::rshr64(64'(r1_p[5]) - 64'(r1_p[6]), 14));
    r2_c[2] <= 38'(qptl_pkg::rshr64(64'(r1_p[7]) - 64'(r1_p[8]), 14));
    r2_q00  <= 18'(qptl_pkg::rshr64(64'(r1_q00), 14));
    sd_r2   <= sd_r1;
  end

  // rotation 3: second quaternion products
  always_ff @(posedge clk) begin
    r3_tx[0] <= r2_qvf * qb[1];
    r3_tx[1] <= r2_q00 * $signed(sd_r2.f[0]);
    r3_tx[2] <= qb[0] * r2_c[0];
    r3_tx[3] <= r2_c[1] * qb[3];
    r3_tx[4] <= qb[2] * r2_c[2];
    r3_ty[0] <= r2_qvf * qb[2];
    r3_ty[1] <= r2_q00 * $signed(sd_r2.f[1]);
    r3_ty[2] <= qb[0] * r2_c[1];
    r3_ty[3] <= r2_c[0] * qb[3];
    r3_ty[4] <= qb[1] * r2_c[2];
    sd_r3    <= sd_r2;
  end

  // rotation 4: body frame force x and y
  always_ff @(posedge clk) begin
    r4_bx <= 48'(qptl_pkg::rshr64(r3_tx[0] + r3_tx[1] + (r3_tx[2] <<< 1)
                                  + (r3_tx[3] - r3_tx[4]), 14));
    r4_by <= 48'(qptl_pkg::rshr64(r3_ty[0] + r3_ty[1] + (r3_ty[2] <<< 1)
                                  - (r3_ty[3] - r3_ty[4]), 14));
    sd_r4 <= sd_r3;
  end

  // output register: torques with damping, thrust select
  always_ff @(posedge clk) begin
    result.roll_torque  <= qptl_pkg::sat32(-64'(r4_by) - 64'($signed(sd_r4.damp[0])));
    result.pitch_torque <= qptl_pkg::sat32(64'(r4_bx) - 64'($signed(sd_r4.damp[1])));
    result.yaw_torque   <= qptl_pkg::sat32(-64'($signed(sd_r4.damp[2])));
    if (sd_r4.man_sel) begin
      result.thrust_command <= sd_r4.man_thr;
    end else begin
      result.thrust_command <= sd_r4.tn[31] ? qptl_pkg::THRUST_MAX : sd_r4.tn[30:0];
    end
  end

endmodule
